[rtl/lss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lss_pkg
// shared types and constants for the lifo stack with search
// ----------------------------------------------------------------------------
package lss_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned DEPTH_W = 9;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

   typedef struct packed {
      logic push;
      logic pop;
      logic load_match;
      logic propagate;
   } cell_cmd_type;

endpackage
`default_nettype wire

[rtl/lifo_stack_with_search.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// bounded lifo stack of 32-bit words held in a chain of cells, with push,
// pop and a membership search over the stored words
// ----------------------------------------------------------------------------
// push, pop and unused codes: result in the cycle after the transfer, and a
// new request can be taken every cycle while no search is busy
// search: result once the scan along the chain has ended, busy until then;
// the hit bits ripple one cell per cycle along the chain to the top cell
// no result can be held off; reset clears the fill count and control state,
// stored words are not cleared
// ----------------------------------------------------------------------------
module lifo_stack_with_search #(
   parameter int unsigned DEPTH = 256
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire         [1:0]                  req_operation,
   input  wire  signed [lss_pkg::WORD_W-1:0]  req_value,
   output logic                               rsp_strobe,
   output logic signed [lss_pkg::WORD_W-1:0]  rsp_popped_value,
   output logic                               rsp_found,
   output logic signed [lss_pkg::WORD_W-1:0]  rsp_top_value,
   output logic        [lss_pkg::DEPTH_W-1:0] rsp_depth_now,
   output logic                               rsp_is_empty,
   output logic                               rsp_overflow
);

   localparam int unsigned CW  = $clog2(DEPTH + 1);
   localparam int unsigned SCW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CW-1:0]  FULL_COUNT = CW'(DEPTH);
   localparam logic [SCW-1:0] SCAN_LEN   = SCW'(DEPTH - 1);

   logic [lss_pkg::WORD_W-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]           cell_hit;
   lss_pkg::cell_cmd_type      cmd;

   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic           search_ff;
   logic           search_in;
   logic [SCW-1:0] scan_ff;
   logic [SCW-1:0] scan_in;
   logic           strobe_ff;
   logic           strobe_in;

   logic [lss_pkg::WORD_W-1:0] popped_ff, popped_in;
   logic                       found_ff, found_in;
   logic [lss_pkg::WORD_W-1:0] top_ff, top_in;
   logic [CW-1:0]              depth_ff, depth_in;
   logic                       ovf_ff, ovf_in;

   logic                       accept;
   logic                       full;
   logic                       empty;
   logic [lss_pkg::WORD_W-1:0] top_cur;
   logic [lss_pkg::WORD_W-1:0] second_word;

   // chain of slots, cell 0 is the top of the stack
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [lss_pkg::WORD_W-1:0] up_w;
      logic [lss_pkg::WORD_W-1:0] down_w;
      logic                       hit_next_w;
      if (i == 0) begin : g_first
         assign up_w = req_value;
      end else begin : g_mid_up
         assign up_w = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign down_w     = '0;
         assign hit_next_w = 1'b0;
      end else begin : g_mid_down
         assign down_w     = cell_data[i+1];
         assign hit_next_w = cell_hit[i+1];
      end
      lss_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .key       (req_value),
         .occupied  (count_ff > CW'(i)),
         .up_data   (up_w),
         .down_data (down_w),
         .hit_next  (hit_next_w),
         .data      (cell_data[i]),
         .hit       (cell_hit[i])
      );
   end

   if (DEPTH > 1) begin : g_second
      assign second_word = cell_data[1];
   end else begin : g_no_second
      assign second_word = lss_pkg::EMPTY_WORD;
   end

   assign busy    = search_ff;
   assign accept  = start && !search_ff;
   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign top_cur = empty ? lss_pkg::EMPTY_WORD : cell_data[0];

   always_comb begin
      cmd       = '0;
      count_in  = count_ff;
      search_in = search_ff;
      scan_in   = scan_ff;
      strobe_in = 1'b0;
      popped_in = '0;
      found_in  = 1'b0;
      top_in    = top_cur;
      depth_in  = count_ff;
      ovf_in    = 1'b0;
      if (search_ff) begin
         if (scan_ff != '0) begin
            cmd.propagate = 1'b1;
            scan_in       = scan_ff - 1'b1;
         end else begin
            search_in = 1'b0;
            strobe_in = 1'b1;
            found_in  = cell_hit[0];
         end
      end else if (accept) begin
         strobe_in = 1'b1;
         unique case (req_operation)
            lss_pkg::OP_PUSH: begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  cmd.push = 1'b1;
                  count_in = count_ff + 1'b1;
                  top_in   = req_value;
               end
            end
            lss_pkg::OP_POP: begin
               if (empty) begin
                  popped_in = lss_pkg::EMPTY_WORD;
               end else begin
                  cmd.pop   = 1'b1;
                  popped_in = cell_data[0];
                  count_in  = count_ff - 1'b1;
                  top_in    = (count_ff == CW'(1)) ? lss_pkg::EMPTY_WORD : second_word;
               end
            end
            lss_pkg::OP_SEARCH: begin
               cmd.load_match = 1'b1;
               search_in      = 1'b1;
               scan_in        = SCAN_LEN;
               strobe_in      = 1'b0;
            end
            default: begin
            end
         endcase
         depth_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         search_ff <= 1'b0;
         scan_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         search_ff <= search_in;
         scan_ff   <= scan_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      popped_ff <= popped_in;
      found_ff  <= found_in;
      top_ff    <= top_in;
      depth_ff  <= depth_in;
      ovf_ff    <= ovf_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_found        = found_ff;
   assign rsp_top_value    = top_ff;
   assign rsp_depth_now    = lss_pkg::DEPTH_W'({{lss_pkg::DEPTH_W{1'b0}}, depth_ff});
   assign rsp_is_empty     = (depth_ff == '0);
   assign rsp_overflow     = ovf_ff;

`ifndef NO_ASSERTIONS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count beyond stack depth");

   a_quiet_search : assert property (@(posedge clock) disable iff (reset)
      search_ff |-> !strobe_ff)
      else $error("result strobe during a search scan");

   a_transfer_answered : assert property (@(posedge clock) disable iff (reset)
      accept |=> (strobe_ff || search_ff))
      else $error("transfer produced neither result nor search");

   a_depth_matches : assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (depth_ff == count_ff))
      else $error("reported depth differs from fill count");

   a_scan_idle : assert property (@(posedge clock) disable iff (reset)
      !search_ff |-> (scan_ff == '0))
      else $error("scan counter running outside a search");
`endif

endmodule
`default_nettype wire

[rtl/lss_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lss_cell
// one stack slot: shifts with its neighbours on push and pop, and holds a
// search hit bit that ripples towards the top of the chain
// ----------------------------------------------------------------------------
module lss_cell (
   input  wire                          clock,
   input  wire lss_pkg::cell_cmd_type   cmd,
   input  wire  [lss_pkg::WORD_W-1:0]   key,
   input  wire                          occupied,
   input  wire  [lss_pkg::WORD_W-1:0]   up_data,
   input  wire  [lss_pkg::WORD_W-1:0]   down_data,
   input  wire                          hit_next,
   output logic [lss_pkg::WORD_W-1:0]   data,
   output logic                         hit
);

   logic [lss_pkg::WORD_W-1:0] data_ff;
   logic [lss_pkg::WORD_W-1:0] data_in;
   logic                       hit_ff;
   logic                       hit_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.push) begin
         data_in = up_data;
      end else if (cmd.pop) begin
         data_in = down_data;
      end
      hit_in = hit_ff;
      if (cmd.load_match) begin
         hit_in = occupied && (data_ff == key);
      end else if (cmd.propagate) begin
         hit_in = hit_ff | hit_next;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
   end

   assign data = data_ff;
   assign hit  = hit_ff;

endmodule
`default_nettype wire

[dv/tb_lifo_stack_with_search.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_search
// self-checking bench for the lifo stack with membership search
// ----------------------------------------------------------------------------
// A short directed sequence runs first. It covers the empty stack, the
// extreme words, every operation and the unused code. Where a result is
// obvious it is typed into the sequence; every other row is predicted.
// Random phases follow: a mixed phase, a fill to full with dropped pushes,
// work at full depth, a drain to empty, and more mixed work. A bench-side
// copy of the stack predicts each result. Every result is compared field
// by field with the oldest prediction, and the request side idles at random.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_search;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STACK_DEPTH = 256;
   localparam int unsigned RANDOM_ITEMS = 600;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [lss_pkg::WORD_W-1:0]  popped;
      logic                        found;
      logic [lss_pkg::WORD_W-1:0]  top;
      logic [lss_pkg::DEPTH_W-1:0] depth;
      logic                        empty;
      logic                        ovf;
   } stack_status_type;

   typedef struct packed {
      logic [1:0]                 op;
      logic [lss_pkg::WORD_W-1:0] word;
      logic                       fixed;
      stack_status_type           want;
   } directed_row_type;

   localparam stack_status_type ST_NONE = '0;
   localparam stack_status_type ST_EMPTY =
      '{32'h0, 1'b0, lss_pkg::EMPTY_WORD, 9'd0, 1'b1, 1'b0};
   localparam stack_status_type ST_POP_EMPTY =
      '{lss_pkg::EMPTY_WORD, 1'b0, lss_pkg::EMPTY_WORD, 9'd0, 1'b1, 1'b0};

   localparam int unsigned N_DIRECTED = 24;
   localparam directed_row_type DIRECTED [N_DIRECTED] = '{
      '{lss_pkg::OP_POP,    32'h0000_0000, 1'b1, ST_POP_EMPTY},
      '{lss_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, ST_EMPTY},
      '{OP_UNUSED,          32'hffff_ffff, 1'b1, ST_EMPTY},
      '{lss_pkg::OP_PUSH,   32'h7fff_ffff, 1'b1,
        '{32'h0, 1'b0, 32'h7fff_ffff, 9'd1, 1'b0, 1'b0}},
      '{lss_pkg::OP_PUSH,   32'h8000_0000, 1'b1,
        '{32'h0, 1'b0, 32'h8000_0000, 9'd2, 1'b0, 1'b0}},
      '{lss_pkg::OP_PUSH,   32'h0000_0000, 1'b1,
        '{32'h0, 1'b0, 32'h0000_0000, 9'd3, 1'b0, 1'b0}},
      '{lss_pkg::OP_PUSH,   32'hffff_ffff, 1'b1,
        '{32'h0, 1'b0, 32'hffff_ffff, 9'd4, 1'b0, 1'b0}},
      '{lss_pkg::OP_SEARCH, 32'h7fff_ffff, 1'b0, ST_NONE},
      '{lss_pkg::OP_SEARCH, 32'h8000_0000, 1'b0, ST_NONE},
      '{lss_pkg::OP_SEARCH, 32'h7fff_fffe, 1'b0, ST_NONE},
      '{lss_pkg::OP_SEARCH, 32'hffff_ffff, 1'b0, ST_NONE},
      '{OP_UNUSED,          32'h0000_0000, 1'b0, ST_NONE},
      '{lss_pkg::OP_POP,    32'h1234_5678, 1'b0, ST_NONE},
      '{lss_pkg::OP_SEARCH, 32'hffff_ffff, 1'b0, ST_NONE},
      '{lss_pkg::OP_POP,    32'h0000_0000, 1'b0, ST_NONE},
      '{lss_pkg::OP_POP,    32'hffff_ffff, 1'b0, ST_NONE},
      '{lss_pkg::OP_PUSH,   32'h5555_5555, 1'b0, ST_NONE},
      '{lss_pkg::OP_PUSH,   32'haaaa_aaaa, 1'b0, ST_NONE},
      '{lss_pkg::OP_SEARCH, 32'haaaa_aaaa, 1'b0, ST_NONE},
      '{lss_pkg::OP_POP,    32'h0000_0000, 1'b0, ST_NONE},
      '{lss_pkg::OP_POP,    32'h0000_0000, 1'b0, ST_NONE},
      '{lss_pkg::OP_POP,    32'h0000_0000, 1'b0, ST_NONE},
      '{lss_pkg::OP_POP,    32'h0000_0000, 1'b1, ST_POP_EMPTY},
      '{lss_pkg::OP_SEARCH, 32'h7fff_ffff, 1'b1, ST_EMPTY}
   };

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic [1:0]                         req_operation = lss_pkg::OP_PUSH;
   logic signed [lss_pkg::WORD_W-1:0]  req_value = '0;
   logic                               rsp_strobe;
   logic signed [lss_pkg::WORD_W-1:0]  rsp_popped_value;
   logic                               rsp_found;
   logic signed [lss_pkg::WORD_W-1:0]  rsp_top_value;
   logic [lss_pkg::DEPTH_W-1:0]        rsp_depth_now;
   logic                               rsp_is_empty;
   logic                               rsp_overflow;

   logic [lss_pkg::WORD_W-1:0] stack_words [STACK_DEPTH];
   int unsigned                stack_fill = 0;
   int unsigned                high_water = 0;
   stack_status_type           expected_status [$];
   stack_status_type           oldest_status;
   int unsigned                mismatch_count = 0;
   int unsigned                items_sent = 0;
   bit                         idle_on = 1'b1;

   lifo_stack_with_search #(
      .DEPTH(STACK_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_popped_value (rsp_popped_value),
      .rsp_found        (rsp_found),
      .rsp_top_value    (rsp_top_value),
      .rsp_depth_now    (rsp_depth_now),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_overflow     (rsp_overflow)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // bench copy of the stack, advanced once per accepted transfer
   function automatic stack_status_type stack_apply(input logic [1:0] op,
                                                    input logic [lss_pkg::WORD_W-1:0] word);
      stack_status_type s;
      s = '0;
      case (op)
         lss_pkg::OP_PUSH: begin
            if (stack_fill < STACK_DEPTH) begin
               stack_words[stack_fill] = word;
               stack_fill++;
               if (stack_fill > high_water) high_water = stack_fill;
            end else begin
               s.ovf = 1'b1;
            end
         end
         lss_pkg::OP_POP: begin
            if (stack_fill == 0) begin
               s.popped = lss_pkg::EMPTY_WORD;
            end else begin
               s.popped = stack_words[stack_fill-1];
               stack_fill--;
            end
         end
         lss_pkg::OP_SEARCH: begin
            for (int i = 0; i < stack_fill; i++)
               if (stack_words[i] == word) s.found = 1'b1;
         end
         default: ;
      endcase
      s.top = (stack_fill == 0) ? lss_pkg::EMPTY_WORD : stack_words[stack_fill-1];
      s.depth = lss_pkg::DEPTH_W'(stack_fill);
      s.empty = (stack_fill == 0);
      return s;
   endfunction

   function automatic logic [lss_pkg::WORD_W-1:0] extreme_word();
      case ($urandom_range(0, 3))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         2: return 32'h8000_0000;
         default: return 32'h7fff_ffff;
      endcase
   endfunction

   function automatic logic [lss_pkg::WORD_W-1:0] pick_push_word();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return extreme_word();
      if (r < 30 && stack_fill != 0) return stack_words[$urandom_range(0, stack_fill-1)];
      return $urandom();
   endfunction

   // stored words, stale words above the top, extremes and noise
   function automatic logic [lss_pkg::WORD_W-1:0] pick_search_word();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50 && stack_fill != 0) return stack_words[$urandom_range(0, stack_fill-1)];
      if (r < 70 && stack_fill < high_water)
         return stack_words[$urandom_range(stack_fill, high_water-1)];
      if (r < 80) return extreme_word();
      return $urandom();
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [lss_pkg::WORD_W-1:0] word,
                            input bit use_fixed, input stack_status_type fixed);
      stack_status_type s;
      int unsigned gap;
      start <= 1'b1;
      req_operation <= op;
      req_value <= word;
      do @(posedge clock); while (busy);
      s = stack_apply(op, word);
      expected_status.push_back(use_fixed ? fixed : s);
      items_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         start <= 1'b0;
         req_operation <= 2'($urandom());
         req_value <= $urandom();
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic run_mix(input int unsigned n_items);
      int unsigned r;
      repeat (n_items) begin
         r = $urandom_range(0, 99);
         if (r < 40) send_item(lss_pkg::OP_PUSH, pick_push_word(), 1'b0, ST_NONE);
         else if (r < 70) send_item(lss_pkg::OP_POP, $urandom(), 1'b0, ST_NONE);
         else if (r < 95) send_item(lss_pkg::OP_SEARCH, pick_search_word(), 1'b0, ST_NONE);
         else send_item(OP_UNUSED, $urandom(), 1'b0, ST_NONE);
      end
   endtask

   task automatic run_fill();
      while (stack_fill < STACK_DEPTH) begin
         if ($urandom_range(0, 99) < 5)
            send_item(lss_pkg::OP_SEARCH, pick_search_word(), 1'b0, ST_NONE);
         else
            send_item(lss_pkg::OP_PUSH, pick_push_word(), 1'b0, ST_NONE);
      end
      repeat ($urandom_range(1, 3)) send_item(lss_pkg::OP_PUSH, $urandom(), 1'b0, ST_NONE);
   endtask

   task automatic run_drain();
      while (stack_fill != 0) send_item(lss_pkg::OP_POP, $urandom(), 1'b0, ST_NONE);
      send_item(lss_pkg::OP_POP, $urandom(), 1'b0, ST_NONE);
   endtask

   function automatic void check_field(input string name,
                                       input logic [lss_pkg::WORD_W-1:0] want,
                                       input logic [lss_pkg::WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_status.size() == 0) begin
            $display("%0t: result with no transfer outstanding, expected none got depth %0d",
                     $time, rsp_depth_now);
            mismatch_count++;
         end else begin
            oldest_status = expected_status.pop_front();
            check_field("popped_value", oldest_status.popped, rsp_popped_value);
            check_field("found", 32'(oldest_status.found), 32'(rsp_found));
            check_field("top_value", oldest_status.top, rsp_top_value);
            check_field("depth_now", 32'(oldest_status.depth), 32'(rsp_depth_now));
            check_field("is_empty", 32'(oldest_status.empty), 32'(rsp_is_empty));
            check_field("overflow", 32'(oldest_status.ovf), 32'(rsp_overflow));
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++)
         send_item(DIRECTED[i].op, DIRECTED[i].word, DIRECTED[i].fixed, DIRECTED[i].want);

      // random phases, with and without idle gaps
      idle_on = 1'b0;
      run_mix(60);
      idle_on = 1'b1;
      run_fill();
      idle_on = 1'b0;
      run_mix(20);
      run_fill();
      idle_on = 1'b1;
      run_drain();
      while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
         idle_on = $urandom_range(0, 3) != 0;
         run_mix(40);
      end

      start <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_lifo_stack_with_search: PASS");
      else
         $display("tb_lifo_stack_with_search: FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_lifo_stack_with_search: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

[lifo_stack_with_search.f]
rtl/lss_pkg.sv
rtl/lss_cell.sv
rtl/lifo_stack_with_search.sv
dv/tb_lifo_stack_with_search.sv
